### src/free_list_block_allocator_assert.svh
// Assertion macros for the allocator checker.
`ifndef FREE_LIST_BLOCK_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_BLOCK_ALLOCATOR_ASSERT_SVH

// Property checked on every clock while out of reset
`define FLBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold on the clock after a trigger
`define FLBA_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

### src/flba_pkg.sv
// Types and codes shared by the free-list allocator modules.
`timescale 1ns / 1ps
package flba_pkg;

  localparam int HDR_BYTES = 4;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_DEFRAG = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // segment table read address source
  typedef enum logic [2:0] {
    RA_I    = 3'd0,
    RA_S    = 3'd1,
    RA_KP1  = 3'd2,
    RA_KM1  = 3'd3,
    RA_BEST = 3'd4
  } rsel_t;

  // segment table write source
  typedef enum logic [2:0] {
    WR_NONE   = 3'd0,
    WR_INIT   = 3'd1,
    WR_AT_K   = 3'd2,
    WR_MERGE  = 3'd3,
    WR_CARVE  = 3'd4,
    WR_HEAD   = 3'd5,
    WR_DEFRAG = 3'd6
  } wsel_t;

  typedef struct packed {
    logic    latch_in;
    logic    div1;
    logic    div2;
    logic    scan_clr;
    logic    i_inc;
    logic    best_upd;
    logic    rd_en;
    rsel_t   rsel;
    wsel_t   wsel;
    logic    blk_rd;
    logic    k_ld_i;
    logic    k_ld_cnt;
    logic    k_inc;
    logic    k_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    blk_from_rd;
    logic    blk_carve;
    logic    afin;
    logic    add_free;
    logic    s_clr;
    logic    s_inc;
    logic    s_ld;
    logic    st_set;
    status_t st_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic bad;
    logic i_lt_cnt;
    logic s_lt_cnt;
    logic k1_lt_cnt;
    logic k_nz;
    logic exact;
    logic better;
    logic fits;
    logic end_hit;
    logic df_hit;
    logic have;
    logic full;
    logic out_free;
  } sts_t;

endpackage

### src/flba_ctrl.sv
// Sequencer for the allocator: walks the free table for each operation.
`timescale 1ns / 1ps
module flba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  flba_pkg::sts_t sts,
  output flba_pkg::cmd_t cmd
);
  import flba_pkg::*;

  typedef enum logic [18:0] {
    S_INIT  = 19'h00001,
    S_IDLE  = 19'h00002,
    S_DIV1  = 19'h00004,
    S_DIV2  = 19'h00008,
    S_FCHK  = 19'h00010,
    S_SRD   = 19'h00020,
    S_SEV   = 19'h00040,
    S_SEND  = 19'h00080,
    S_ABEV  = 19'h00100,
    S_AFIN  = 19'h00200,
    S_RMRD  = 19'h00400,
    S_RMWR  = 19'h00800,
    S_INSRD = 19'h01000,
    S_INSWR = 19'h02000,
    S_DSRD  = 19'h04000,
    S_DSEV  = 19'h08000,
    S_DFRD  = 19'h10000,
    S_DFEV  = 19'h20000,
    S_DONE  = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // next state and datapath commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        cmd.wsel  = WR_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd.div1  = 1'b1;
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        cmd.div2     = 1'b1;
        cmd.scan_clr = 1'b1;
        cmd.s_clr    = 1'b1;
        case (sts.op)
          OP_FREE:   state_nxt = S_FCHK;
          OP_DEFRAG: state_nxt = S_DSRD;
          default:   state_nxt = S_SRD;
        endcase
      end
      S_FCHK: begin
        // malformed address is dropped with status ok
        if (sts.bad) begin
          state_nxt = S_DONE;
        end else begin
          cmd.blk_rd = 1'b1;
          state_nxt  = S_SRD;
        end
      end
      S_SRD: begin
        if (sts.i_lt_cnt) begin
          cmd.rd_en = 1'b1;
          cmd.rsel  = RA_I;
          state_nxt = S_SEV;
        end else begin
          state_nxt = S_SEND;
        end
      end
      S_SEV: begin
        case (sts.op)
          OP_ALLOC: begin
            if (sts.exact) begin
              cmd.blk_from_rd = 1'b1;
              cmd.k_ld_i      = 1'b1;
              state_nxt       = S_RMRD;
            end else begin
              cmd.best_upd = sts.better;
              cmd.i_inc    = 1'b1;
              state_nxt    = S_SRD;
            end
          end
          OP_QUERY: begin
            if (sts.fits) begin
              state_nxt = S_DONE;
            end else begin
              cmd.i_inc = 1'b1;
              state_nxt = S_SRD;
            end
          end
          OP_FREE: begin
            if (sts.end_hit) begin
              cmd.wsel     = WR_MERGE;
              cmd.add_free = 1'b1;
              state_nxt    = S_DONE;
            end else begin
              cmd.i_inc = 1'b1;
              state_nxt = S_SRD;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SEND: begin
        case (sts.op)
          OP_ALLOC: begin
            if (sts.have) begin
              cmd.rd_en = 1'b1;
              cmd.rsel  = RA_BEST;
              state_nxt = S_ABEV;
            end else begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_NONE;
              state_nxt   = S_DONE;
            end
          end
          OP_FREE: begin
            if (sts.full) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_FULL;
              state_nxt   = S_DONE;
            end else begin
              cmd.k_ld_cnt = 1'b1;
              state_nxt    = S_INSRD;
            end
          end
          OP_QUERY: begin
            cmd.st_set  = 1'b1;
            cmd.st_code = ST_NONE;
            state_nxt   = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_ABEV: begin
        cmd.wsel      = WR_CARVE;
        cmd.blk_carve = 1'b1;
        state_nxt     = S_AFIN;
      end
      S_AFIN: begin
        cmd.afin  = 1'b1;
        state_nxt = S_DONE;
      end
      // close the gap left by a removed entry
      S_RMRD: begin
        if (sts.k1_lt_cnt) begin
          cmd.rd_en = 1'b1;
          cmd.rsel  = RA_KP1;
          state_nxt = S_RMWR;
        end else begin
          cmd.cnt_dec = 1'b1;
          if (sts.op == OP_ALLOC) begin
            state_nxt = S_AFIN;
          end else begin
            cmd.s_clr = 1'b1;
            state_nxt = S_DSRD;
          end
        end
      end
      S_RMWR: begin
        cmd.wsel  = WR_AT_K;
        cmd.k_inc = 1'b1;
        state_nxt = S_RMRD;
      end
      // open a slot at the head
      S_INSRD: begin
        if (sts.k_nz) begin
          cmd.rd_en = 1'b1;
          cmd.rsel  = RA_KM1;
          state_nxt = S_INSWR;
        end else begin
          cmd.wsel     = WR_HEAD;
          cmd.cnt_inc  = 1'b1;
          cmd.add_free = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_INSWR: begin
        cmd.wsel  = WR_AT_K;
        cmd.k_dec = 1'b1;
        state_nxt = S_INSRD;
      end
      // defragment: outer entry
      S_DSRD: begin
        if (sts.s_lt_cnt) begin
          cmd.rd_en = 1'b1;
          cmd.rsel  = RA_S;
          state_nxt = S_DSEV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DSEV: begin
        cmd.s_ld     = 1'b1;
        cmd.scan_clr = 1'b1;
        state_nxt    = S_DFRD;
      end
      // defragment: inner search for a follower
      S_DFRD: begin
        if (sts.i_lt_cnt) begin
          cmd.rd_en = 1'b1;
          cmd.rsel  = RA_I;
          state_nxt = S_DFEV;
        end else begin
          cmd.s_inc = 1'b1;
          state_nxt = S_DSRD;
        end
      end
      S_DFEV: begin
        if (sts.df_hit) begin
          cmd.wsel   = WR_DEFRAG;
          cmd.k_ld_i = 1'b1;
          state_nxt  = S_RMRD;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = S_DFRD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

### src/flba_dp.sv
// Allocator datapath: free table, block size store, counters, result register.
`timescale 1ns / 1ps
module flba_dp #(
  parameter int POOL_UNITS   = 1024,
  parameter int MAX_SEGMENTS = 64,
  parameter int UNIT_BYTES   = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     in_op,
  input  logic [15:0]    in_size_bytes,
  input  logic [14:0]    in_address,
  input  flba_pkg::cmd_t cmd,
  output flba_pkg::sts_t sts,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [1:0]     out_status,
  output logic [14:0]    out_alloc_address,
  output logic [15:0]    out_free_bytes
);
  import flba_pkg::*;

  localparam int LW         = $clog2(POOL_UNITS + 1);
  localparam int SW         = $clog2(POOL_UNITS);
  localparam int AW         = $clog2(MAX_SEGMENTS);
  localparam int IW         = $clog2(MAX_SEGMENTS + 1);
  localparam int POOL_BYTES = POOL_UNITS * UNIT_BYTES;
  localparam int FBW        = $clog2(POOL_BYTES + 1);
  localparam int XW         = 17;
  localparam int NW         = 17;
  localparam int CMPW       = (LW > NW) ? LW : NW;
  localparam int EW         = CMPW + 1;
  localparam int CW0        = (FBW > LW + 9) ? FBW : LW + 9;
  localparam int CW         = ((CW0 > XW) ? CW0 : XW) + 1;
  localparam int RK         = 26;
  localparam int RM         = (1 << RK) / UNIT_BYTES + 1;
  localparam int PRODW      = RK + NW;
  localparam int QBW        = NW + 10;
  localparam int ABW        = LW + 10;

  // free table and block size store
  logic [SW-1:0] seg_start_mem [MAX_SEGMENTS];
  logic [LW-1:0] seg_len_mem   [MAX_SEGMENTS];
  logic [LW-1:0] blk_mem       [POOL_UNITS];

  op_t           op_r;
  logic [XW-1:0] x_r;
  logic          bad_lo_r, bad_r;
  logic [NW-1:0] q_r;
  logic [SW-1:0] rd_start_r, sstart_r;
  logic [LW-1:0] rd_len_r, slen_r, bestlen_r, blen_r, blk_r;
  logic [IW-1:0] cnt_r, i_r, k_r, s_r, best_r;
  logic          have_r;
  logic [CW-1:0] fbc_r;
  status_t       res_status_r;
  logic [14:0]   res_addr_r;
  logic          out_valid_r;
  status_t       out_status_r;
  logic [14:0]   out_addr_r;
  logic [15:0]   out_fb_r;

  logic [PRODW-1:0] prod;
  logic [QBW-1:0]   qback;
  logic [IW-1:0]    raddr;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [SW-1:0]    wstart;
  logic [LW-1:0]    wlen;
  logic [EW-1:0]    rend, send;
  logic [CW-1:0]    sub_d, add_a, add_sum;
  logic [ABW-1:0]   abytes;

  // merged length limited to the end of the pool
  function automatic logic [LW-1:0] capped(input logic [SW-1:0] st, input logic [LW:0] sum);
    logic [LW:0] room;
    room = (LW+1)'(POOL_UNITS) - (LW+1)'(st);
    return (sum > room) ? room[LW-1:0] : sum[LW-1:0];
  endfunction

  // divide by the unit size via reciprocal multiply
  assign prod  = PRODW'(x_r) * PRODW'(RM);
  assign qback = QBW'(q_r) * QBW'(UNIT_BYTES);

  assign rend = EW'(rd_start_r) + EW'(rd_len_r);
  assign send = EW'(sstart_r) + EW'(slen_r);

  assign sub_d   = CW'(q_r) * CW'(UNIT_BYTES);
  assign add_a   = CW'(blen_r) * CW'(UNIT_BYTES);
  assign add_sum = fbc_r + add_a;
  assign abytes  = ABW'(blk_r) * ABW'(UNIT_BYTES) + ABW'(HDR_BYTES);

  // status to the sequencer
  always_comb begin
    sts.op        = op_r;
    sts.bad       = bad_r;
    sts.i_lt_cnt  = (i_r < cnt_r);
    sts.s_lt_cnt  = (s_r < cnt_r);
    sts.k1_lt_cnt = ((IW+1)'(k_r) + (IW+1)'(1)) < (IW+1)'(cnt_r);
    sts.k_nz      = (k_r != '0);
    sts.exact     = (CMPW'(rd_len_r) == CMPW'(q_r));
    sts.fits      = (CMPW'(rd_len_r) >= CMPW'(q_r));
    sts.better    = (CMPW'(rd_len_r) > CMPW'(q_r)) && (!have_r || rd_len_r < bestlen_r);
    sts.end_hit   = (rend == EW'(q_r));
    sts.df_hit    = (i_r != s_r) && (EW'(rd_start_r) == send);
    sts.have      = have_r;
    sts.full      = (cnt_r >= IW'(MAX_SEGMENTS));
    sts.out_free  = !out_valid_r || out_ready;
  end

  // table read address
  always_comb begin
    case (cmd.rsel)
      RA_S:    raddr = s_r;
      RA_KP1:  raddr = k_r + IW'(1);
      RA_KM1:  raddr = k_r - IW'(1);
      RA_BEST: raddr = best_r;
      default: raddr = i_r;
    endcase
  end

  // table write port
  always_comb begin
    we     = 1'b1;
    waddr  = '0;
    wstart = rd_start_r;
    wlen   = rd_len_r;
    case (cmd.wsel)
      WR_INIT: begin
        wstart = '0;
        wlen   = LW'(POOL_UNITS);
      end
      WR_AT_K: waddr = k_r[AW-1:0];
      WR_MERGE: begin
        waddr = i_r[AW-1:0];
        wlen  = capped(rd_start_r, (LW+1)'(rd_len_r) + (LW+1)'(blen_r));
      end
      WR_CARVE: begin
        waddr = best_r[AW-1:0];
        wlen  = rd_len_r - LW'(q_r);
      end
      WR_HEAD: begin
        wstart = q_r[SW-1:0];
        wlen   = capped(q_r[SW-1:0], (LW+1)'(blen_r));
      end
      WR_DEFRAG: begin
        waddr  = s_r[AW-1:0];
        wstart = sstart_r;
        wlen   = capped(sstart_r, (LW+1)'(slen_r) + (LW+1)'(rd_len_r));
      end
      default: we = 1'b0;
    endcase
  end

  // memories with registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      seg_start_mem[waddr] <= wstart;
      seg_len_mem[waddr]   <= wlen;
    end
    if (cmd.rd_en) begin
      rd_start_r <= seg_start_mem[raddr[AW-1:0]];
      rd_len_r   <= seg_len_mem[raddr[AW-1:0]];
    end
    if (cmd.blk_rd) begin
      blen_r <= blk_mem[q_r[SW-1:0]];
    end
    if (cmd.afin && (EW'(blk_r) < EW'(POOL_UNITS))) begin
      blk_mem[blk_r[SW-1:0]] <= q_r[LW-1:0];
    end
  end

  // payload and index registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r         <= op_t'(in_op);
      bad_lo_r     <= (in_address < 15'(HDR_BYTES));
      res_status_r <= ST_OK;
      res_addr_r   <= '0;
      if (op_t'(in_op) == OP_FREE) begin
        x_r <= XW'(in_address) - XW'(HDR_BYTES);
      end else begin
        x_r <= XW'(in_size_bytes) + XW'(UNIT_BYTES + HDR_BYTES - 1);
      end
    end
    if (cmd.div1) begin
      q_r <= prod[PRODW-1:RK];
    end
    if (cmd.div2) begin
      bad_r <= bad_lo_r || (qback != QBW'(x_r)) || ((NW+1)'(q_r) >= (NW+1)'(POOL_UNITS));
    end
    if (cmd.scan_clr) begin
      i_r    <= '0;
      have_r <= 1'b0;
    end else if (cmd.i_inc) begin
      i_r <= i_r + IW'(1);
    end
    if (cmd.best_upd) begin
      best_r    <= i_r;
      bestlen_r <= rd_len_r;
      have_r    <= 1'b1;
    end
    if (cmd.k_ld_i) begin
      k_r <= i_r;
    end else if (cmd.k_ld_cnt) begin
      k_r <= cnt_r;
    end else if (cmd.k_inc) begin
      k_r <= k_r + IW'(1);
    end else if (cmd.k_dec) begin
      k_r <= k_r - IW'(1);
    end
    if (cmd.s_clr) begin
      s_r <= '0;
    end else if (cmd.s_inc) begin
      s_r <= s_r + IW'(1);
    end
    if (cmd.s_ld) begin
      sstart_r <= rd_start_r;
      slen_r   <= rd_len_r;
    end
    if (cmd.blk_from_rd) begin
      blk_r <= LW'(rd_start_r);
    end else if (cmd.blk_carve) begin
      blk_r <= LW'(rd_start_r) + (rd_len_r - LW'(q_r));
    end
    if (cmd.afin) begin
      res_addr_r <= 15'(abytes);
    end
    if (cmd.st_set) begin
      res_status_r <= cmd.st_code;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_fb_r     <= fbc_r[15:0];
    end
  end

  // control state: entry count, free byte count, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= IW'(1);
      fbc_r       <= CW'(POOL_BYTES);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + IW'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - IW'(1);
      end
      if (cmd.afin) begin
        fbc_r <= (sub_d > fbc_r) ? '0 : fbc_r - sub_d;
      end else if (cmd.add_free) begin
        fbc_r <= (add_sum > CW'(POOL_BYTES)) ? CW'(POOL_BYTES) : add_sum;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_alloc_address = out_addr_r;
  assign out_free_bytes    = out_fb_r;

endmodule

### src/free_list_block_allocator.sv
// Top level of the free-list block allocator.
// Usage:
//   Input words carry in_op (0 allocate, 1 free, 2 query, 3 defragment),
//   in_size_bytes and in_address, taken when in_valid and in_ready are high.
//   Each word yields one result word: out_status, out_alloc_address and
//   out_free_bytes, taken when out_valid and out_ready are high.
//   One word is worked on at a time; in_ready is high only while idle.
//   The time per word grows with the free-table entries scanned and with the
//   entries shifted on a remove or a head insert. A free may scan every
//   entry and then shift all of them for a head insert. The defragment
//   pairwise search restarts after each merge, so a defragment can take up
//   to about N search passes for N entries.
//   After reset the block writes the initial pool entry before it goes idle.
//   A finished result sits in the output register; the next word is accepted
//   meanwhile, and its result waits until the previous one is taken.
`timescale 1ns / 1ps
module free_list_block_allocator #(
  parameter int POOL_UNITS   = 1024,
  parameter int MAX_SEGMENTS = 64,
  parameter int UNIT_BYTES   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_size_bytes,
  input  logic [14:0] in_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [14:0] out_alloc_address,
  output logic [15:0] out_free_bytes
);
  import flba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  flba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  flba_dp #(
    .POOL_UNITS   (POOL_UNITS),
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .UNIT_BYTES   (UNIT_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_op             (in_op),
    .in_size_bytes     (in_size_bytes),
    .in_address        (in_address),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_alloc_address (out_alloc_address),
    .out_free_bytes    (out_free_bytes)
  );

endmodule

### src/flba_checker.sv
// Port-level checker for the allocator, bound to the top level.
`timescale 1ns / 1ps
`include "free_list_block_allocator_assert.svh"
module flba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [14:0] out_alloc_address
);
  import flba_pkg::*;

  // a stalled result stays presented
  `FLBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // only defined status codes leave the block
  `FLBA_ASSERT(a_status_code, out_valid |-> (out_status <= ST_FULL), "undefined status")

  // failed operations return no address
  `FLBA_ASSERT(a_fail_addr, (out_valid && out_status != ST_OK) |-> (out_alloc_address == 15'd0), "address on failure")

  // one word in flight: busy right after an accept
  `FLBA_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "accepted word while busy")

endmodule

bind free_list_block_allocator flba_checker u_flba_checker (.*);
